// ----- src/ipc_pkg.sv -----
// Package for the interval profile counter bank: sizes, item layouts,
// per-slot memory records, operation codes and controller states.
// No dependencies.
package ipc_pkg;

  localparam int SLOT_COUNT    = 128;
  localparam int SLOT_W        = 7;
  localparam int TICK_W        = 48;
  localparam int CALLS_W       = 32;
  localparam int TOT_CALLS_W   = 48;
  localparam int TOT_TICKS_W   = 64;
  localparam int ADDR_W        = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int DIV_CNT_W     = $clog2(TOT_TICKS_W);

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_END   = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLOSE,
    ST_DIV,
    ST_CLWR
  } state_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [SLOT_W-1:0] slot;
    logic [47:0]       timestamp;
    logic              clear_history;
    logic [47:0]       limit_ticks;
  } req_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot_out;
    logic              ever_ended;
    logic [31:0]       epoch_calls;
    logic [47:0]       epoch_elapsed;
    logic [47:0]       min_elapsed;
    logic [47:0]       max_elapsed;
    logic [47:0]       avg_elapsed;
    logic [47:0]       running_ticks;
    logic              over_limit;
  } rsp_item_t;

  // Open-epoch state of one slot.
  typedef struct packed {
    logic [TICK_W-1:0]  start_stamp;
    logic [CALLS_W-1:0] open_calls;
    logic [TICK_W-1:0]  open_ticks;
    logic               ended_flag;
  } live_t;

  // Closed-epoch history of one slot.
  typedef struct packed {
    logic [CALLS_W-1:0]     closed_calls;
    logic [TICK_W-1:0]      closed_ticks;
    logic [TOT_CALLS_W-1:0] total_calls;
    logic [TOT_TICKS_W-1:0] total_ticks;
    logic [TICK_W-1:0]      min_ticks;
    logic [TICK_W-1:0]      max_ticks;
    logic [TICK_W-1:0]      avg_ticks;
    logic                   history_seeded;
  } hist_t;

endpackage

// ----- src/ipc_req_if.sv -----
// Request channel of the interval profile counter bank.
// Depends on ipc_pkg for the item layout.
interface ipc_req_if;
  import ipc_pkg::*;

  logic      valid;
  logic      ready;
  req_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/ipc_rsp_if.sv -----
// Result channel of the interval profile counter bank.
// Depends on ipc_pkg for the item layout.
interface ipc_rsp_if;
  import ipc_pkg::*;

  logic      valid;
  logic      ready;
  rsp_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- src/ipc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module ipc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- src/interval_profile_counter_bank_core.sv -----
// Interval profile counter bank: per-slot interval timing statistics.
// Depends on ipc_pkg, ipc_req_if, ipc_rsp_if and ipc_ram.
//
// Requests arrive on req, one item per operation: start stamps a slot,
// end adds the elapsed ticks to the slot's open epoch, close ends the
// epoch for every slot, and read reports one slot. Only a read gives a
// result item on rsp; the other operations give none.
// Start, end and read each read the slot from the two state memories
// (registered read data) and then write back or load the result register.
// A close walks all SLOT_COUNT slots; a slot that had calls in the epoch,
// on a close that keeps history, also takes its average from a 64-step
// shift-subtract divider before its history is written back.
// After reset the block sweeps both memories to zero, one slot per cycle,
// and accepts no request meanwhile.
// Results wait in an output register; new requests are still taken while
// a result waits, but a following read holds until that register is free.
module interval_profile_counter_bank_core (
  input logic clk,
  input logic rst,
  ipc_req_if.sink   req,
  ipc_rsp_if.source rsp
);
  import ipc_pkg::*;

  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(SLOT_COUNT - 1);

  state_t state, state_next;
  logic [ADDR_W-1:0] idx, idx_next;
  logic [ADDR_W-1:0] addr, addr_next;
  req_item_t op, op_next;
  logic out_valid, out_valid_next;
  rsp_item_t out_data, out_data_next;
  hist_t hold, hold_next;
  logic [TOT_TICKS_W-1:0] quo, quo_next;
  logic [TOT_CALLS_W-1:0] rem, rem_next;
  logic [TOT_CALLS_W-1:0] divisor, divisor_next;
  logic [DIV_CNT_W-1:0] cnt, cnt_next;

  logic live_we, hist_we;
  logic [ADDR_W-1:0] waddr, raddr;
  live_t live_wdata, live_rd;
  hist_t hist_wdata, hist_rd, rec;
  logic slot_ok;

  logic [TICK_W-1:0] gap;
  logic [TICK_W:0] ticks_sum;
  logic [TOT_CALLS_W:0] tc_sum;
  logic [TOT_TICKS_W:0] tt_sum;
  logic [TOT_CALLS_W-1:0] tc_new;
  logic [TOT_TICKS_W-1:0] tt_new;
  logic [TOT_CALLS_W:0] trial;
  logic need_div;

  ipc_ram #(.WIDTH($bits(live_t)), .DEPTH(SLOT_COUNT)) u_live_ram (
    .clk(clk), .we(live_we), .waddr(waddr), .wdata(live_wdata),
    .raddr(raddr), .rdata(live_rd)
  );

  ipc_ram #(.WIDTH($bits(hist_t)), .DEPTH(SLOT_COUNT)) u_hist_ram (
    .clk(clk), .we(hist_we), .waddr(waddr), .wdata(hist_wdata),
    .raddr(raddr), .rdata(hist_rd)
  );

  assign slot_ok = int'(op.slot) < SLOT_COUNT;

  // End of interval: wrapped gap, saturating accumulator.
  assign gap = op.timestamp[TICK_W-1:0] - live_rd.start_stamp;
  assign ticks_sum = {1'b0, live_rd.open_ticks} + {1'b0, gap};

  // Epoch close: saturating totals.
  assign tc_sum = {1'b0, hist_rd.total_calls} + (TOT_CALLS_W + 1)'(live_rd.open_calls);
  assign tc_new = tc_sum[TOT_CALLS_W] ? '1 : tc_sum[TOT_CALLS_W-1:0];
  assign tt_sum = {1'b0, hist_rd.total_ticks} + (TOT_TICKS_W + 1)'(live_rd.open_ticks);
  assign tt_new = tt_sum[TOT_TICKS_W] ? '1 : tt_sum[TOT_TICKS_W-1:0];
  assign need_div = !op.clear_history && (live_rd.open_calls != '0);

  always_comb begin
    rec = hist_rd;
    rec.closed_calls = live_rd.open_calls;
    rec.closed_ticks = live_rd.open_ticks;
    rec.total_calls = tc_new;
    rec.total_ticks = tt_new;
    rec.avg_ticks = '0;
    if (op.clear_history) begin
      rec.min_ticks = '0;
      rec.max_ticks = '0;
      rec.history_seeded = 1'b0;
    end else if (!hist_rd.history_seeded) begin
      // The first close after a clear seeds both extremes.
      rec.min_ticks = live_rd.open_ticks;
      rec.max_ticks = live_rd.open_ticks;
      rec.history_seeded = 1'b1;
    end else begin
      if (live_rd.open_ticks < hist_rd.min_ticks) rec.min_ticks = live_rd.open_ticks;
      if (live_rd.open_ticks > hist_rd.max_ticks) rec.max_ticks = live_rd.open_ticks;
    end
  end

  // One restoring division step: bring down the next dividend bit.
  assign trial = {rem, quo[TOT_TICKS_W-1]};

  always_comb begin
    state_next = state;
    idx_next = idx;
    addr_next = addr;
    op_next = op;
    out_valid_next = out_valid && !rsp.ready;
    out_data_next = out_data;
    hold_next = hold;
    quo_next = quo;
    rem_next = rem;
    divisor_next = divisor;
    cnt_next = cnt;
    live_we = 1'b0;
    hist_we = 1'b0;
    live_wdata = '0;
    hist_wdata = '0;
    waddr = addr;
    raddr = addr;
    req.ready = 1'b0;

    case (state)
      ST_INIT: begin
        live_we = 1'b1;
        hist_we = 1'b1;
        waddr = idx;
        if (idx == LAST) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = ADDR_W'(idx + 1'b1);
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        raddr = req.data.slot[ADDR_W-1:0];
        if (req.valid) begin
          op_next = req.data;
          addr_next = req.data.slot[ADDR_W-1:0];
          if (req.data.mode == MODE_CLOSE) begin
            idx_next = '0;
            raddr = '0;
            state_next = ST_CLOSE;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        state_next = ST_IDLE;
        live_wdata = live_rd;
        case (op.mode)
          MODE_START: begin
            live_we = slot_ok;
            live_wdata.start_stamp = op.timestamp[TICK_W-1:0];
          end
          MODE_END: begin
            live_we = slot_ok;
            live_wdata.open_ticks = ticks_sum[TICK_W] ? '1 : ticks_sum[TICK_W-1:0];
            live_wdata.open_calls = (live_rd.open_calls == '1) ? live_rd.open_calls
                                                                 : live_rd.open_calls + 1'b1;
            live_wdata.ended_flag = 1'b1;
          end
          MODE_READ: begin
            if (out_valid && !rsp.ready) begin
              state_next = ST_EXEC;
            end else begin
              out_valid_next = 1'b1;
              out_data_next = '0;
              out_data_next.slot_out = op.slot;
              if (slot_ok) begin
                out_data_next.ever_ended = live_rd.ended_flag;
                out_data_next.epoch_calls = hist_rd.closed_calls;
                out_data_next.epoch_elapsed = hist_rd.closed_ticks;
                out_data_next.min_elapsed = hist_rd.min_ticks;
                out_data_next.max_elapsed = hist_rd.max_ticks;
                out_data_next.avg_elapsed = hist_rd.avg_ticks;
                out_data_next.running_ticks = live_rd.open_ticks;
                out_data_next.over_limit = live_rd.open_ticks >= op.limit_ticks;
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_CLOSE: begin
        live_we = 1'b1;
        waddr = idx;
        live_wdata.ended_flag = op.clear_history ? 1'b0 : live_rd.ended_flag;
        if (need_div) begin
          hold_next = rec;
          quo_next = tt_new;
          rem_next = '0;
          divisor_next = tc_new;
          cnt_next = DIV_CNT_W'(TOT_TICKS_W - 1);
          state_next = ST_DIV;
        end else begin
          hist_we = 1'b1;
          hist_wdata = rec;
          raddr = ADDR_W'(idx + 1'b1);
          if (idx == LAST) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = ADDR_W'(idx + 1'b1);
          end
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, divisor}) begin
          rem_next = TOT_CALLS_W'(trial - {1'b0, divisor});
          quo_next = {quo[TOT_TICKS_W-2:0], 1'b1};
        end else begin
          rem_next = trial[TOT_CALLS_W-1:0];
          quo_next = {quo[TOT_TICKS_W-2:0], 1'b0};
        end
        cnt_next = DIV_CNT_W'(cnt - 1'b1);
        if (cnt == '0) begin
          state_next = ST_CLWR;
        end
      end
      ST_CLWR: begin
        hist_we = 1'b1;
        waddr = idx;
        hist_wdata = hold;
        hist_wdata.avg_ticks = (quo[TOT_TICKS_W-1:TICK_W] != '0) ? '1 : quo[TICK_W-1:0];
        raddr = ADDR_W'(idx + 1'b1);
        if (idx == LAST) begin
          state_next = ST_IDLE;
        end else begin
          idx_next = ADDR_W'(idx + 1'b1);
          state_next = ST_CLOSE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      idx <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      out_valid <= out_valid_next;
    end
    addr <= addr_next;
    op <= op_next;
    out_data <= out_data_next;
    hold <= hold_next;
    quo <= quo_next;
    rem <= rem_next;
    divisor <= divisor_next;
    cnt <= cnt_next;
  end

  assign rsp.valid = out_valid;
  assign rsp.data = out_data;
endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for interval_profile_counter_bank_core.
// Depends on ipc_pkg, ipc_req_if, ipc_rsp_if and the core itself; a scoreboard
// class predicts each read result from its own model of the slot statistics.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ipc_pkg::*;

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;
  localparam int RANDOM_ITEMS = 625;

  class stats_scoreboard;
    logic [63:0] start_stamp [SLOT_COUNT];
    logic [63:0] open_calls [SLOT_COUNT];
    logic [63:0] open_ticks [SLOT_COUNT];
    logic [63:0] closed_calls [SLOT_COUNT];
    logic [63:0] closed_ticks [SLOT_COUNT];
    logic [63:0] total_calls [SLOT_COUNT];
    logic [63:0] total_ticks [SLOT_COUNT];
    logic [63:0] min_ticks [SLOT_COUNT];
    logic [63:0] max_ticks [SLOT_COUNT];
    logic [63:0] avg_ticks [SLOT_COUNT];
    bit ended [SLOT_COUNT];
    bit seeded [SLOT_COUNT];
    rsp_item_t expected_reads[$];
    int mismatches;
    int reads_seen;
    int closes_seen;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        start_stamp[i] = 0; open_calls[i] = 0; open_ticks[i] = 0;
        closed_calls[i] = 0; closed_ticks[i] = 0; total_calls[i] = 0;
        total_ticks[i] = 0; min_ticks[i] = 0; max_ticks[i] = 0;
        avg_ticks[i] = 0; ended[i] = 0; seeded[i] = 0;
      end
      mismatches = 0;
      reads_seen = 0;
      closes_seen = 0;
    endfunction

    function void close_all(bit clear);
      logic [63:0] t;
      logic [64:0] sum;
      logic [63:0] q;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        t = open_ticks[i];
        closed_calls[i] = open_calls[i];
        sum = total_calls[i] + open_calls[i];
        total_calls[i] = (sum >= MASK48) ? MASK48 : sum[63:0];
        closed_ticks[i] = t;
        sum = {1'b0, total_ticks[i]} + t;
        total_ticks[i] = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
        if (clear) begin
          min_ticks[i] = 0; max_ticks[i] = 0; avg_ticks[i] = 0;
          ended[i] = 0; seeded[i] = 0;
        end else begin
          if (!seeded[i]) begin
            min_ticks[i] = t; max_ticks[i] = t; seeded[i] = 1;
          end else begin
            if (t < min_ticks[i]) min_ticks[i] = t;
            if (t > max_ticks[i]) max_ticks[i] = t;
          end
          if (open_calls[i] != 0 && total_calls[i] != 0) begin
            q = total_ticks[i] / total_calls[i];
            avg_ticks[i] = (q > MASK48) ? MASK48 : q;
          end else begin
            avg_ticks[i] = 0;
          end
        end
        open_calls[i] = 0; open_ticks[i] = 0; start_stamp[i] = 0;
      end
    endfunction

    function void note_request(req_item_t it);
      int s;
      logic [63:0] gap;
      logic [63:0] sum;
      rsp_item_t r;
      s = it.slot;
      case (mode_t'(it.mode))
        MODE_START: start_stamp[s] = {16'd0, it.timestamp};
        MODE_END: begin
          gap = ({16'd0, it.timestamp} - start_stamp[s]) & MASK48;
          sum = open_ticks[s] + gap;
          open_ticks[s] = (sum >= MASK48) ? MASK48 : sum;
          if (open_calls[s] != MASK32) open_calls[s] = open_calls[s] + 1;
          ended[s] = 1;
        end
        MODE_CLOSE: begin
          close_all(it.clear_history);
          closes_seen++;
        end
        default: begin
          r.slot_out = it.slot;
          r.ever_ended = ended[s];
          r.epoch_calls = closed_calls[s][31:0];
          r.epoch_elapsed = closed_ticks[s][47:0];
          r.min_elapsed = min_ticks[s][47:0];
          r.max_elapsed = max_ticks[s][47:0];
          r.avg_elapsed = avg_ticks[s][47:0];
          r.running_ticks = open_ticks[s][47:0];
          r.over_limit = (open_ticks[s] >= {16'd0, it.limit_ticks});
          expected_reads.push_back(r);
        end
      endcase
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t e;
      bit bad;
      if (expected_reads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %h", got);
        return;
      end
      e = expected_reads.pop_front();
      reads_seen++;
      bad = (got.slot_out != e.slot_out) || (got.ever_ended != e.ever_ended) ||
            (got.epoch_calls != e.epoch_calls) || (got.epoch_elapsed != e.epoch_elapsed) ||
            (got.min_elapsed != e.min_elapsed) || (got.max_elapsed != e.max_elapsed) ||
            (got.avg_elapsed != e.avg_elapsed) || (got.running_ticks != e.running_ticks) ||
            (got.over_limit != e.over_limit);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("read of slot %0d mismatch", e.slot_out);
          $display("  expected slot %0d end %0d calls %h ep %h min %h max %h avg %h run %h ov %0d",
                   e.slot_out, e.ever_ended, e.epoch_calls, e.epoch_elapsed, e.min_elapsed,
                   e.max_elapsed, e.avg_elapsed, e.running_ticks, e.over_limit);
          $display("  actual   slot %0d end %0d calls %h ep %h min %h max %h avg %h run %h ov %0d",
                   got.slot_out, got.ever_ended, got.epoch_calls, got.epoch_elapsed,
                   got.min_elapsed, got.max_elapsed, got.avg_elapsed, got.running_ticks,
                   got.over_limit);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  ipc_req_if req ();
  ipc_rsp_if rsp ();
  stats_scoreboard board;
  bit idle_off;
  bit long_hold_req;
  int items_sent;

  interval_profile_counter_bank_core dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[interval_profile_counter_bank_core] ERROR");
    $finish;
  end

  // Both channels are sampled at the edge, before any driver update lands.
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) board.note_request(req.data);
    if (!rst && rsp.valid && rsp.ready) board.check_result(rsp.data);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    int hold;
    rsp.ready = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        rsp.ready <= 0;
      end else if (!idle_off && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 3);
        rsp.ready <= 0;
      end else begin
        rsp.ready <= 1;
      end
    end
  end

  // Called at the edge that accepted the previous item, so the next item
  // replaces it before the following edge.
  task automatic send_item(req_item_t it);
    int gap;
    if (!idle_off && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.data <= it;
    do @(posedge clk); while (!req.ready);
    items_sent++;
  endtask

  function automatic req_item_t make_item(mode_t m, int s, logic [47:0] ts,
                                          bit clr, logic [47:0] lim);
    req_item_t it;
    it.mode = m;
    it.slot = s[6:0];
    it.timestamp = ts;
    it.clear_history = clr;
    it.limit_ticks = lim;
    return it;
  endfunction

  function automatic logic [47:0] rand48();
    return {16'($urandom_range(0, 65535)), $urandom()};
  endfunction

  function automatic logic [47:0] rand_span();
    case ($urandom_range(0, 9))
      0: return rand48();
      1: return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 100));
      default: return 48'($urandom_range(0, 5000));
    endcase
  endfunction

  initial begin
    logic [47:0] stamp [SLOT_COUNT];
    logic [47:0] ts;
    req_item_t it;
    int s;
    int pick;
    board = new();
    idle_off = 0;
    long_hold_req = 0;
    items_sent = 0;
    for (int i = 0; i < SLOT_COUNT; i++) stamp[i] = 0;
    req.valid = 0;
    req.data = '0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;

    // Directed: extremes of every field, wrap, saturation, seeding and clears.
    send_item(make_item(MODE_READ, 0, 48'h0, 1'b1, 48'h0));
    send_item(make_item(MODE_START, 5, 48'h0, 1'b0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(MODE_END, 5, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0));
    send_item(make_item(MODE_END, 5, 48'hFFFF_FFFF_FFFF, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 5, 48'h0, 1'b0, 48'hFFFF_FFFF_FFFF));
    send_item(make_item(MODE_READ, 5, 48'hFFFF_FFFF_FFFF, 1'b1, 48'h0));
    send_item(make_item(MODE_START, 127, 48'hFFFF_FFFF_FFF0, 1'b0, 48'h0));
    send_item(make_item(MODE_END, 127, 48'h3, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 127, 48'h0, 1'b0, 48'h13));
    send_item(make_item(MODE_READ, 127, 48'h0, 1'b0, 48'h14));
    send_item(make_item(MODE_END, 0, 48'h64, 1'b0, 48'h0));
    send_item(make_item(MODE_CLOSE, 0, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 127, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 5, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 1, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_START, 0, 48'h10, 1'b0, 48'h0));
    send_item(make_item(MODE_END, 0, 48'h20, 1'b0, 48'h0));
    send_item(make_item(MODE_CLOSE, 0, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 0, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_CLOSE, 0, 48'h0, 1'b1, 48'h0));
    send_item(make_item(MODE_READ, 0, 48'h0, 1'b0, 48'h0));
    // First close after a clear seeds min and max even with no calls.
    send_item(make_item(MODE_CLOSE, 0, 48'h0, 1'b0, 48'h0));
    send_item(make_item(MODE_READ, 0, 48'h0, 1'b0, 48'h0));

    // Sender pause until every outstanding read has been answered.
    req.valid <= 0;
    while (board.expected_reads.size() != 0) @(posedge clk);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 120) long_hold_req = 1;
      if (n == RANDOM_ITEMS - 80) idle_off = 1;
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SLOT_COUNT - 1)
                                      : $urandom_range(0, 7);
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        it = make_item(MODE_CLOSE, s, rand48(), $urandom_range(0, 4) == 0, rand48());
        for (int i = 0; i < SLOT_COUNT; i++) stamp[i] = 0;
      end else if (pick < 30) begin
        ts = ($urandom_range(0, 4) == 0) ? rand48() : stamp[s] + $urandom_range(0, 2000);
        stamp[s] = ts;
        it = make_item(MODE_START, s, ts, 1'($urandom_range(0, 1)), rand48());
      end else if (pick < 60) begin
        ts = stamp[s] + rand_span();
        it = make_item(MODE_END, s, ts, 1'($urandom_range(0, 1)), rand48());
      end else begin
        it = make_item(MODE_READ, s, rand48(), 1'($urandom_range(0, 1)),
                       ($urandom_range(0, 1) == 0) ? rand48() : rand_span());
      end
      send_item(it);
    end
    req.valid <= 0;

    while (board.expected_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Sent %0d items: %0d reads checked, %0d epoch closes, %0d mismatches.",
             items_sent, board.reads_seen, board.closes_seen, board.mismatches);
    if (board.mismatches == 0 && board.expected_reads.size() == 0)
      $display("[interval_profile_counter_bank_core] OK");
    else
      $display("[interval_profile_counter_bank_core] ERROR");
    $finish;
  end
endmodule
